### rtl/core/stts_pkg.sv
// Package: widths, reset values and material constants of the tank thermal step.
`default_nettype none

package stts_pkg;

    localparam int NODES_DEF = 16;

    localparam logic [15:0] HEIGHT_RST = 16'd1024;
    localparam logic [15:0] AREA_RST   = 16'd256;
    localparam logic [15:0] TSTEP_RST  = 16'd16;
    localparam logic        MODE_RST   = 1'b0;

    // register indexes on the configuration port
    localparam logic [1:0] REG_HEIGHT = 2'd0;
    localparam logic [1:0] REG_AREA   = 2'd1;
    localparam logic [1:0] REG_TSTEP  = 2'd2;
    localparam logic [1:0] REG_MODE   = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // material constants scaled by 100, 10 and 100000
    localparam int RHOW = 17;
    localparam logic [RHOW-1:0] RHO_HEAT = 17'd99222;
    localparam logic [RHOW-1:0] RHO_COOL = 17'd99974;
    localparam logic [63:0] CP_HEAT  = 64'd41794;
    localparam logic [63:0] CP_COOL  = 64'd41960;
    localparam logic [63:0] LAM_HEAT = 64'd62848;
    localparam logic [63:0] LAM_COOL = 64'd57772;

    // diffusion coefficient width and gain width
    localparam int DW = 36;
    localparam int GW = 40;
    localparam logic [GW-1:0] GAIN_CAP = {GW{1'b1}};

    // floor(lam * 2^56 / den) by long division, evaluated at elaboration
    function automatic logic [DW-1:0] f_diff_coef(input logic [63:0] lam,
                                                  input logic [63:0] den);
        logic [127:0] n;
        logic [127:0] r;
        logic [127:0] q;
        begin
            n = {64'd0, lam} << 56;
            r = '0;
            q = '0;
            for (int i = 127; i >= 0; i--) begin
                r = {r[126:0], n[i]};
                if (r >= {64'd0, den}) begin
                    r = r - {64'd0, den};
                    q[i] = 1'b1;
                end
            end
            return q[DW-1:0];
        end
    endfunction

    localparam logic [DW-1:0] D_HEAT =
        f_diff_coef(LAM_HEAT, 64'd100 * 64'd99222 * CP_HEAT);
    localparam logic [DW-1:0] D_COOL =
        f_diff_coef(LAM_COOL, 64'd100 * 64'd99974 * CP_COOL);

endpackage

`default_nettype wire

### rtl/core/stratified_tank_thermal_step.sv
// Top level: tank profile memory, gain computation and node update sweep.
//
// Usage. A command is taken on a rising edge with start high and busy low.
// A load command writes one node of the profile memory in that edge and
// leaves busy low; an index of NODES or more is dropped. A step command
// computes the advection gain K1 and the diffusion gain K2, then sweeps the
// profile memory bottom to top through a three-node window, one node read
// per cycle, and emits one result per node on o_valid, node 0 first, with
// o_last on the top node and o_is_outlet on the outlet node.
// A step runs S_MUL1 and S_MUL2, then two divisions, each a load state and
// a division state shifting through the DIVW-bit dividend (DIVW = 79 for 16
// nodes, one quotient bit per cycle in the shared restoring divider), then
// the sweep and update pipeline. busy stays high until the last result is
// shown; a load or step may be taken in the cycle that shows the last
// result. Results are strobed for one cycle each; the receiver cannot
// stall. Configuration is to be written over the APB port only while idle;
// the block does not enforce this. Reset restores the register defaults and
// clears control state; the profile memory is undefined until loaded.
`default_nettype none

module stratified_tank_thermal_step #(
    parameter int NODES = stts_pkg::NODES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [5:0]         i_load_index,
    input  logic [15:0]        i_load_temp,
    input  logic signed [15:0] i_mass_flow,
    input  logic [15:0]        i_inlet_temp,
    output logic               o_valid,
    output logic [5:0]         o_out_index,
    output logic [15:0]        o_out_temp,
    output logic               o_is_outlet,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import stts_pkg::*;

    localparam int AW    = $clog2(NODES);
    localparam int CW    = $clog2(NODES + 2);
    localparam int SPAN  = NODES - 1;
    localparam int SP16  = SPAN * 1600;
    localparam int SP16W = $clog2(SP16 + 1);
    localparam int SQ    = SPAN * SPAN;
    localparam int SQW   = $clog2(SQ + 1);
    localparam int K1NW  = 32 + SP16W;
    localparam int DENW  = 32 + RHOW;
    localparam int K2NW  = DW + 16 + SQW;
    localparam int DIVW  = (K1NW + 32 > K2NW) ? K1NW + 32 : K2NW;
    localparam int DCW   = $clog2(DIVW);
    localparam int ACCW  = 62;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL1  = 6'b000010,
        S_MUL2  = 6'b000100,
        S_DLOAD = 6'b001000,
        S_DIV   = 6'b010000,
        S_SWEEP = 6'b100000
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_height, r_area, r_tstep;
    logic        r_mode;

    // latched step command
    logic [15:0] r_mag, r_inlet;
    logic        r_up, r_down;

    // gain datapath
    logic [31:0]        r_p_mt, r_p_ah, r_p_hh;
    logic [DW+15:0]     r_p_dts;
    logic [K1NW-1:0]    r_num_k1;
    logic [DENW-1:0]    r_den_k1;
    logic [K2NW-1:0]    r_num_k2;
    logic [DENW-1:0]    r_den_k2;
    logic [DIVW-1:0]    r_dvd;
    logic [DENW-1:0]    r_den;
    logic [DENW:0]      r_rem;
    logic [GW:0]        r_q;
    logic               r_sat, r_nz, r_dsel;
    logic [DCW-1:0]     r_dcnt;
    logic [GW-1:0]      r_k1, r_k2;

    // sweep
    logic [CW-1:0]      r_cnt;
    logic [15:0]        r_mem [NODES];
    logic [15:0]        r_rdata, r_prv, r_cur;

    // update pipeline
    logic                    r_vb;
    logic signed [GW+17:0]   r_m1;
    logic signed [GW+18:0]   r_m2;
    logic [15:0]             r_bt;
    logic                    r_binl;
    logic [AW-1:0]           r_bidx;

    logic        accept, cfg_wr, load_wr;
    logic        is_step;
    logic [DENW:0]   trial;
    logic            qbit;
    logic [DENW:0]   n_rem;
    logic [GW:0]     n_q;
    logic            n_sat;
    logic [GW-1:0]   gain;
    logic            a_valid, a_last_slot;
    logic [AW-1:0]   a_idx;
    logic [15:0]     a_lower, a_upper;
    logic            a_inl;
    logic signed [16:0] a_dadv;
    logic signed [17:0] a_ddiff;
    logic signed [ACCW-1:0] c_acc;
    logic [15:0]     c_temp;
    logic [RHOW-1:0] rho;
    logic [DW-1:0]   dcoef;

    assign accept  = start && !busy;
    assign is_step = (i_command == CMD_STEP);
    assign load_wr = accept && !is_step && ({1'b0, i_load_index} < 7'(NODES));
    assign busy    = (r_state != S_IDLE) || r_vb;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    assign rho   = r_mode ? RHO_COOL : RHO_HEAT;
    assign dcoef = r_mode ? D_COOL : D_HEAT;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HEIGHT_RST;
            r_area   <= AREA_RST;
            r_tstep  <= TSTEP_RST;
            r_mode   <= MODE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_HEIGHT: r_height <= pwdata[15:0];
                REG_AREA:   r_area   <= pwdata[15:0];
                REG_TSTEP:  r_tstep  <= pwdata[15:0];
                REG_MODE:   r_mode   <= pwdata[0];
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HEIGHT: prdata = {16'd0, r_height};
            REG_AREA:   prdata = {16'd0, r_area};
            REG_TSTEP:  prdata = {16'd0, r_tstep};
            REG_MODE:   prdata = {31'd0, r_mode};
            default:    prdata = '0;
        endcase
    end

    // one restoring division step
    always_comb begin
        trial = {r_rem[DENW-1:0], r_dvd[DIVW-1]};
        qbit  = (trial >= {1'b0, r_den});
        n_rem = qbit ? trial - {1'b0, r_den} : trial;
        n_q   = {r_q[GW-1:0], qbit};
        n_sat = r_sat || r_q[GW];
        if (!r_nz) begin
            gain = '0;
        end else if (n_sat || n_q[GW]) begin
            gain = GAIN_CAP;
        end else begin
            gain = n_q[GW-1:0];
        end
    end

    // sweep window: slot k of the counter computes node k-2
    always_comb begin
        a_valid     = (r_state == S_SWEEP) && (r_cnt >= CW'(2));
        a_last_slot = (r_cnt == CW'(NODES + 1));
        a_idx       = AW'(r_cnt - CW'(2));
        a_lower     = (a_idx == '0) ? r_cur : r_prv;
        a_upper     = a_last_slot ? r_cur : r_rdata;
        a_inl       = (r_up && a_idx == '0) || (r_down && a_idx == AW'(NODES - 1));
        if (r_up) begin
            a_dadv = $signed({1'b0, a_lower}) - $signed({1'b0, r_cur});
        end else if (r_down) begin
            a_dadv = $signed({1'b0, a_upper}) - $signed({1'b0, r_cur});
        end else begin
            a_dadv = '0;
        end
        a_ddiff = $signed({2'b00, a_lower}) + $signed({2'b00, a_upper})
                - $signed({1'b0, r_cur, 1'b0});
    end

    // accumulate, round half up, saturate
    always_comb begin
        c_acc = $signed({14'd0, r_bt, 32'd0}) + ACCW'(r_m1) + ACCW'(r_m2)
              + $signed(ACCW'(64'h8000_0000));
        if (c_acc[ACCW-1]) begin
            c_temp = '0;
        end else if (c_acc[ACCW-2:48] != '0) begin
            c_temp = 16'hFFFF;
        end else begin
            c_temp = c_acc[47:32];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vb    <= 1'b0;
            o_valid <= 1'b0;
            r_cnt   <= '0;
            r_dcnt  <= '0;
            r_dsel  <= 1'b0;
        end else begin
            r_vb    <= a_valid;
            o_valid <= r_vb;
            case (r_state)
                S_IDLE: begin
                    if (accept && is_step) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: begin
                    r_dsel  <= 1'b0;
                    r_state <= S_DLOAD;
                end
                S_DLOAD: begin
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + DCW'(1);
                    if (r_dcnt == DCW'(DIVW - 1)) begin
                        if (!r_dsel) begin
                            r_dsel  <= 1'b1;
                            r_state <= S_DLOAD;
                        end else begin
                            r_cnt   <= '0;
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (a_last_slot) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept && is_step) begin
            r_inlet <= i_inlet_temp;
            r_up    <= !i_mass_flow[15] && (i_mass_flow != '0);
            r_down  <= i_mass_flow[15];
            r_mag   <= i_mass_flow[15] ? 16'(~i_mass_flow + 16'sd1) : i_mass_flow;
        end
        if (r_state == S_MUL1) begin
            r_p_mt  <= 32'(r_mag) * 32'(r_tstep);
            r_p_ah  <= 32'(r_area) * 32'(r_height);
            r_p_hh  <= 32'(r_height) * 32'(r_height);
            r_p_dts <= (DW+16)'(dcoef) * (DW+16)'(r_tstep);
        end
        if (r_state == S_MUL2) begin
            r_num_k1 <= K1NW'(r_p_mt) * K1NW'(SP16);
            r_den_k1 <= DENW'(r_p_ah) * DENW'(rho);
            r_num_k2 <= K2NW'(r_p_dts) * K2NW'(SQ);
            r_den_k2 <= DENW'({r_p_hh, 8'd0});
        end
        if (r_state == S_DLOAD) begin
            if (r_dsel) begin
                r_dvd <= DIVW'(r_num_k2);
                r_den <= r_den_k2;
                r_nz  <= (r_num_k2 != '0);
            end else begin
                r_dvd <= DIVW'({r_num_k1, 32'd0});
                r_den <= r_den_k1;
                r_nz  <= (r_num_k1 != '0);
            end
            r_rem <= '0;
            r_q   <= '0;
            r_sat <= 1'b0;
        end
        if (r_state == S_DIV) begin
            r_dvd <= {r_dvd[DIVW-2:0], 1'b0};
            r_rem <= n_rem;
            r_q   <= n_q;
            r_sat <= n_sat;
            if (r_dcnt == DCW'(DIVW - 1)) begin
                if (r_dsel) begin
                    r_k2 <= gain;
                end else begin
                    r_k1 <= gain;
                end
            end
        end
        // advance the window
        if (r_state == S_SWEEP && r_cnt != '0 && !a_last_slot) begin
            r_prv <= r_cur;
            r_cur <= r_rdata;
        end
        if (a_valid) begin
            r_m1   <= $signed({1'b0, r_k1}) * a_dadv;
            r_m2   <= $signed({1'b0, r_k2}) * a_ddiff;
            r_bt   <= r_cur;
            r_binl <= a_inl;
            r_bidx <= a_idx;
        end
        if (r_vb) begin
            o_out_index <= 6'(r_bidx);
            o_out_temp  <= r_binl ? r_inlet : c_temp;
            o_is_outlet <= r_down ? (r_bidx == '0) : (r_bidx == AW'(NODES - 1));
            o_last      <= (r_bidx == AW'(NODES - 1));
        end
    end

    // profile memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_mem[AW'(i_load_index)] <= i_load_temp;
        end else if (r_vb) begin
            r_mem[r_bidx] <= r_binl ? r_inlet : c_temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt < CW'(NODES)) begin
            r_rdata <= r_mem[r_cnt[AW-1:0]];
        end
    end

endmodule

`default_nettype wire
